@@ rtl/core/lspp_pkg.sv @@
// Types, constants and elaboration-time table builders for the scan point projection.
`default_nettype none

package lspp_pkg;

  // Angle constants, Q28 radian
  localparam logic [30:0] TWO_PI_Q28    = 31'd1686629713;
  localparam logic [30:0] PI_Q28        = 31'd843314857;
  localparam logic [30:0] HALF_TURN_MAX = 31'd843314856;
  localparam logic [30:0] HALF_PI_Q28   = 31'd421657428;

  // Beams at or beyond this index are dropped
  localparam int unsigned MAX_BEAMS = 4096;

  // Offset that makes start + index * step non-negative; a multiple of two pi
  localparam logic [45:0] ANG_OFFSET = 46'(TWO_PI_Q28) << 13;

  // Reciprocal of two pi, scaled by 2^56, for the quotient estimate
  localparam logic [63:0] RECIP_FULL = (64'd1 << 56) / 64'(TWO_PI_Q28);
  localparam logic [25:0] RECIP_2PI  = RECIP_FULL[25:0];

  // CORDIC datapath width for x and y
  localparam int XW = 43;

  // Output saturation bounds
  localparam logic signed [XW:0] OUT_MAX = (XW+1)'(64'sd4294967295);
  localparam logic signed [XW:0] OUT_MIN = (XW+1)'(-64'sd4294967296);

  // Configuration register map
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANGLE_START   = 3'd0,
    CFG_ANGLE_STEP    = 3'd1,
    CFG_RANGE_LOW     = 3'd2,
    CFG_RANGE_HIGH    = 3'd3,
    CFG_WINDOW_ENABLE = 3'd4,
    CFG_WINDOW_FROM   = 3'd5,
    CFG_WINDOW_TO     = 3'd6
  } cfg_reg_t;

  // Shift-subtract division, used only to build constants at elaboration
  function automatic logic [63:0] lspp_udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    int b;
    rem = '0;
    q   = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/n) in Q62 by its power series
  function automatic logic signed [63:0] lspp_atan_inv_q62(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] nn;
    logic signed [63:0] sum;
    logic done;
    int k;
    p    = lspp_udiv64(64'd1 << 62, n);
    nn   = n * n;
    sum  = signed'(p);
    done = 1'b0;
    for (k = 1; k < 64; k++) begin
      if (!done) begin
        p = lspp_udiv64(p, nn);
        if (p == 64'd0) begin
          done = 1'b1;
        end else if (k[0]) begin
          sum = sum - signed'(lspp_udiv64(p, 64'(2 * k + 1)));
        end else begin
          sum = sum + signed'(lspp_udiv64(p, 64'(2 * k + 1)));
        end
      end
    end
    return sum;
  endfunction

  // round(atan(2^-i) * 2^28)
  function automatic logic signed [31:0] lspp_atan_q28(input int i);
    logic signed [63:0] v;
    if (i == 0) begin
      v = lspp_atan_inv_q62(64'd2) + lspp_atan_inv_q62(64'd3);
    end else begin
      v = lspp_atan_inv_q62(64'd1 << i);
    end
    v = (v + (64'sd1 <<< 33)) >>> 34;
    return v[31:0];
  endfunction

  // Integer square root, bit-pair method
  function automatic logic [63:0] lspp_isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    int j;
    v   = v_in;
    res = '0;
    bt  = 64'd1 << 62;
    for (j = 0; j < 32; j++) begin
      if (bt > v) bt = bt >> 2;
    end
    for (j = 0; j < 32; j++) begin
      if (bt != 64'd0) begin
        if (v >= res + bt) begin
          v   = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return res;
  endfunction

  // CORDIC gain compensation in Q31 for the given number of iterations
  function automatic logic [63:0] lspp_gain_q31(input int stages);
    logic [63:0] k2;
    int i;
    k2 = 64'd1 << 62;
    for (i = 0; i < stages; i++) begin
      k2 = k2 - lspp_udiv64(k2, (64'd1 << (2 * i)) + 64'd1);
    end
    return lspp_isqrt64(k2);
  endfunction

  // Reduce a 32-bit angle into (-pi, pi]
  function automatic logic signed [31:0] lspp_norm32(input logic signed [31:0] v);
    logic signed [33:0] m;
    m = 34'(v);
    if (m < 0) m = m + 34'(TWO_PI_Q28);
    if (m < 0) m = m + 34'(TWO_PI_Q28);
    if (m >= 34'(TWO_PI_Q28)) m = m - 34'(TWO_PI_Q28);
    if (m > 34'(HALF_TURN_MAX)) m = m - 34'(TWO_PI_Q28);
    return m[31:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/laser_scan_point_projection_top.sv @@
// Top level: range-scanner beam to Cartesian point projection pipeline.
`default_nettype none

// One beam is taken in every clock cycle (busy stays low) and a kept beam
// shows its point on out_point_x / out_point_y for exactly one cycle with
// out_valid high, registered behind the sign-fix stage.
// The receiver cannot hold results off. Beams that are not finite, out of
// the range bounds, at an index of MAX_BEAMS or more, or outside the enabled
// angular window give no word at all; kept beams leave in arrival order.
// The path is the chain of fully pipelined stages: range check and
// index multiply, gain multiply, a four-stage reduction of the angle modulo
// two pi, the window and quadrant stage, one stage per CORDIC iteration, then
// sign fix and round/saturate. Write configuration only while the pipeline
// is empty; window bounds take effect once wf_r / wt_r have registered them.
module laser_scan_point_projection_top
  import lspp_pkg::*;
#(
  parameter int CORDIC_STAGES = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // beam input
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [31:0]            in_beam_range,
  input  wire logic                   in_range_finite,
  input  wire logic [11:0]            in_beam_index,
  // point output
  output logic                        out_valid,
  output logic signed [32:0]          out_point_x,
  output logic signed [32:0]          out_point_y,
  // configuration write
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [31:0]            cfg_data
);

  localparam logic [63:0] GAIN_FULL = lspp_gain_q31(CORDIC_STAGES);
  localparam logic [30:0] GAIN      = GAIN_FULL[30:0];

  // Signed copies of the fold limits for the quadrant compare
  localparam logic signed [31:0] HALF_PI_S = 32'(HALF_PI_Q28);
  localparam logic signed [31:0] PI_S      = 32'(PI_Q28);

  // Configuration registers
  logic signed [31:0] angle_start_r;
  logic signed [31:0] angle_step_r;
  logic [31:0]        range_low_r;
  logic [31:0]        range_high_r;
  logic               window_enable_r;
  logic signed [31:0] window_from_r;
  logic signed [31:0] window_to_r;
  logic signed [31:0] wf_r;
  logic signed [31:0] wt_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_start_r   <= '0;
      angle_step_r    <= '0;
      range_low_r     <= '0;
      range_high_r    <= '1;
      window_enable_r <= 1'b0;
      window_from_r   <= '0;
      window_to_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ANGLE_START:   angle_start_r   <= cfg_data;
        CFG_ANGLE_STEP:    angle_step_r    <= cfg_data;
        CFG_RANGE_LOW:     range_low_r     <= cfg_data;
        CFG_RANGE_HIGH:    range_high_r    <= cfg_data;
        CFG_WINDOW_ENABLE: window_enable_r <= cfg_data[0];
        CFG_WINDOW_FROM:   window_from_r   <= cfg_data;
        CFG_WINDOW_TO:     window_to_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Normalized window bounds, refreshed every cycle
  always_ff @(posedge clk) begin
    wf_r <= lspp_norm32(window_from_r);
    wt_r <= lspp_norm32(window_to_r);
  end

  // Stage 1: range check, index times step
  logic               accept;
  logic               range_ok;
  logic signed [12:0] idx_s;
  logic               s1_valid_r;
  logic [31:0]        s1_range_r;
  logic signed [44:0] s1_prod_r;

  assign accept   = start && !busy;
  assign idx_s    = {1'b0, in_beam_index};
  assign range_ok = in_range_finite && (in_beam_range >= range_low_r) &&
                    (in_beam_range <= range_high_r) &&
                    (32'(in_beam_index) < 32'(MAX_BEAMS));

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= accept && range_ok;
    s1_range_r <= in_beam_range;
    s1_prod_r  <= 45'(idx_s) * 45'(angle_step_r);
  end

  // Stage 2: offset angle sum, scaled start x
  logic        s2_valid_r;
  logic [44:0] s2_u_r;
  logic [39:0] s2_x0_r;
  logic [45:0] s2_u_nxt;
  logic [63:0] x0_prod;

  assign s2_u_nxt = 46'(angle_start_r) + 46'(s1_prod_r) + ANG_OFFSET;
  assign x0_prod  = 64'(s1_range_r) * 64'(GAIN);

  always_ff @(posedge clk) begin
    if (!rst_n) s2_valid_r <= 1'b0;
    else        s2_valid_r <= s1_valid_r;
    s2_u_r  <= s2_u_nxt[44:0];
    s2_x0_r <= x0_prod[62:23];
  end

  // Stage 3: quotient estimate by reciprocal multiply
  logic        s3_valid_r;
  logic [44:0] s3_u_r;
  logic [39:0] s3_x0_r;
  logic [50:0] s3_qp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_valid_r <= 1'b0;
    else        s3_valid_r <= s2_valid_r;
    s3_u_r  <= s2_u_r;
    s3_x0_r <= s2_x0_r;
    s3_qp_r <= 51'(s2_u_r[44:20]) * 51'(RECIP_2PI);
  end

  // Stage 4: quotient times two pi
  logic        s4_valid_r;
  logic [44:0] s4_u_r;
  logic [39:0] s4_x0_r;
  logic [44:0] s4_qm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_valid_r <= 1'b0;
    else        s4_valid_r <= s3_valid_r;
    s4_u_r  <= s3_u_r;
    s4_x0_r <= s3_x0_r;
    s4_qm_r <= 45'(s3_qp_r[50:36]) * 45'(TWO_PI_Q28);
  end

  // Stage 5: remainder, below twice two pi
  logic        s5_valid_r;
  logic [31:0] s5_m_r;
  logic [39:0] s5_x0_r;
  logic [44:0] rem_full;

  assign rem_full = s4_u_r - s4_qm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s5_valid_r <= 1'b0;
    else        s5_valid_r <= s4_valid_r;
    s5_m_r  <= rem_full[31:0];
    s5_x0_r <= s4_x0_r;
  end

  // Stage 6: final correction, fold into (-pi, pi]
  logic               s6_valid_r;
  logic signed [31:0] s6_a_r;
  logic [39:0]        s6_x0_r;
  logic [32:0]        m1;
  logic [32:0]        a_nxt;

  always_comb begin
    if (s5_m_r >= 32'(TWO_PI_Q28)) m1 = 33'(s5_m_r) - 33'(TWO_PI_Q28);
    else                           m1 = 33'(s5_m_r);
    if (m1 > 33'(HALF_TURN_MAX)) a_nxt = m1 - 33'(TWO_PI_Q28);
    else                         a_nxt = m1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s6_valid_r <= 1'b0;
    else        s6_valid_r <= s5_valid_r;
    s6_a_r  <= a_nxt[31:0];
    s6_x0_r <= s5_x0_r;
  end

  // Stage 7: window test and quadrant fold, feeds CORDIC stage 0
  logic signed [XW-1:0] cx_r [CORDIC_STAGES+1];
  logic signed [XW-1:0] cy_r [CORDIC_STAGES+1];
  logic signed [31:0]   cz_r [CORDIC_STAGES+1];
  logic                 cf_r [CORDIC_STAGES+1];
  logic                 cv_r [CORDIC_STAGES+1];

  logic               win_in;
  logic               win_ok;
  logic signed [31:0] z_nxt;
  logic               flip_nxt;

  always_comb begin
    if (wf_r <= wt_r) win_in = (s6_a_r >= wf_r) && (s6_a_r <= wt_r);
    else              win_in = (s6_a_r >= wf_r) || (s6_a_r <= wt_r);
    win_ok = !window_enable_r || win_in;
    priority if (s6_a_r > HALF_PI_S) begin
      z_nxt    = s6_a_r - PI_S;
      flip_nxt = 1'b1;
    end else if (s6_a_r < -HALF_PI_S) begin
      z_nxt    = s6_a_r + PI_S;
      flip_nxt = 1'b1;
    end else begin
      z_nxt    = s6_a_r;
      flip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cv_r[0] <= 1'b0;
    else        cv_r[0] <= s6_valid_r && win_ok;
    cx_r[0] <= XW'(s6_x0_r);
    cy_r[0] <= '0;
    cz_r[0] <= z_nxt;
    cf_r[0] <= flip_nxt;
  end

  // CORDIC rotation, one iteration per stage
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    localparam logic signed [31:0] ATAN_I = lspp_atan_q28(i);

    always_ff @(posedge clk) begin
      if (!rst_n) cv_r[i+1] <= 1'b0;
      else        cv_r[i+1] <= cv_r[i];
      cf_r[i+1] <= cf_r[i];
      if (cz_r[i] >= 0) begin
        cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
        cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
        cz_r[i+1] <= cz_r[i] - ATAN_I;
      end else begin
        cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
        cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
        cz_r[i+1] <= cz_r[i] + ATAN_I;
      end
    end
  end

  // Sign fix for folded angles
  logic                 nv_r;
  logic signed [XW-1:0] nx_r;
  logic signed [XW-1:0] ny_r;

  always_ff @(posedge clk) begin
    if (!rst_n) nv_r <= 1'b0;
    else        nv_r <= cv_r[CORDIC_STAGES];
    nx_r <= cf_r[CORDIC_STAGES] ? -cx_r[CORDIC_STAGES] : cx_r[CORDIC_STAGES];
    ny_r <= cf_r[CORDIC_STAGES] ? -cy_r[CORDIC_STAGES] : cy_r[CORDIC_STAGES];
  end

  // Round to Q16 and saturate
  logic signed [XW:0]   rx;
  logic signed [XW:0]   ry;
  logic signed [32:0]   px_nxt;
  logic signed [32:0]   py_nxt;
  logic                 out_valid_r;
  logic signed [32:0]   out_x_r;
  logic signed [32:0]   out_y_r;

  always_comb begin
    rx = ((XW+1)'(nx_r) + (XW+1)'(128)) >>> 8;
    ry = ((XW+1)'(ny_r) + (XW+1)'(128)) >>> 8;
    if (rx > OUT_MAX)      px_nxt = OUT_MAX[32:0];
    else if (rx < OUT_MIN) px_nxt = OUT_MIN[32:0];
    else                   px_nxt = rx[32:0];
    if (ry > OUT_MAX)      py_nxt = OUT_MAX[32:0];
    else if (ry < OUT_MIN) py_nxt = OUT_MIN[32:0];
    else                   py_nxt = ry[32:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= nv_r;
    out_x_r <= px_nxt;
    out_y_r <= py_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_point_x = out_x_r;
  assign out_point_y = out_y_r;

endmodule

`default_nettype wire

@@ dv/scan_point_checker.sv @@
`timescale 1ns / 100ps
// Checker for the scan point projection: watches all channels, predicts and compares points.
module scan_point_checker
  import lspp_pkg::*;
#(
  parameter int CORDIC_STAGES = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 busy,
  input  wire logic [31:0]          in_beam_range,
  input  wire logic                 in_range_finite,
  input  wire logic [11:0]          in_beam_index,
  input  wire logic                 out_valid,
  input  wire logic signed [32:0]   out_point_x,
  input  wire logic signed [32:0]   out_point_y,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  output int                        mismatch_count,
  output int                        pending
);

  localparam int ITERS = (CORDIC_STAGES > 32) ? 32 : ((CORDIC_STAGES < 1) ? 1 : CORDIC_STAGES);
  localparam longint TURN      = longint'(TWO_PI_Q28);
  localparam longint HALF_TURN = longint'(PI_Q28);
  localparam longint TURN_TOP  = longint'(HALF_TURN_MAX);
  localparam longint QUARTER   = longint'(HALF_PI_Q28);
  localparam longint SAT_HI    = longint'(OUT_MAX);
  localparam longint SAT_LO    = longint'(OUT_MIN);

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
  } point_t;

  point_t             pending_points[$];
  longint             atan_tab[32];
  longint unsigned    gain_q31;

  // shadow copy of the configuration registers
  logic signed [31:0] ang_start, ang_step, win_from, win_to;
  logic [31:0]        rng_low, rng_high;
  logic               win_en;

  // atan(1/n) in Q62 from the alternating power series
  function automatic longint arctan_recip_q62(input longint unsigned n);
    longint unsigned p, nn, k;
    longint acc;
    p   = (64'd1 << 62) / n;
    nn  = n * n;
    acc = longint'(p);
    k   = 1;
    while (1) begin
      p = p / nn;
      if (p == 0) break;
      if (k[0]) acc -= longint'(p / (2 * k + 1));
      else      acc += longint'(p / (2 * k + 1));
      k++;
    end
    return acc;
  endfunction

  // reduce an angle into (-pi, pi]
  function automatic longint wrap_angle(input longint a);
    longint m;
    m = a % TURN;
    if (m < 0) m += TURN;
    if (m > TURN_TOP) m -= TURN;
    return m;
  endfunction

  // predicted point of one beam; returns 0 when the beam is dropped
  function automatic logic project_beam(input logic [31:0] r, input logic fin,
                                        input logic [11:0] idx, output point_t pt);
    longint ang, wf, wt, z, x, y, dx, dy;
    logic flip, in_win;
    pt = '0;
    if (!fin || r < rng_low || r > rng_high || idx >= MAX_BEAMS) return 1'b0;
    ang = wrap_angle(longint'(ang_start) + longint'(idx) * longint'(ang_step));
    if (win_en) begin
      wf = wrap_angle(longint'(win_from));
      wt = wrap_angle(longint'(win_to));
      in_win = (wf <= wt) ? (ang >= wf && ang <= wt) : (ang >= wf || ang <= wt);
      if (!in_win) return 1'b0;
    end
    // fold the angle into the right half plane
    z = ang;
    flip = 1'b0;
    if (z > QUARTER) begin
      z -= HALF_TURN;
      flip = 1'b1;
    end else if (z < -QUARTER) begin
      z += HALF_TURN;
      flip = 1'b1;
    end
    x = longint'((64'(r) * gain_q31) >> 23);
    y = 0;
    // rotation mode iterations, arithmetic shifts floor
    for (int i = 0; i < ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_tab[i];
      end else begin
        x += dx;
        y -= dy;
        z += atan_tab[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    // round to Q16 and saturate
    x = (x + 128) >>> 8;
    y = (y + 128) >>> 8;
    if (x > SAT_HI) x = SAT_HI;
    if (x < SAT_LO) x = SAT_LO;
    if (y > SAT_HI) y = SAT_HI;
    if (y < SAT_LO) y = SAT_LO;
    pt.x = x[32:0];
    pt.y = y[32:0];
    return 1'b1;
  endfunction

  // arctangent table and gain compensation
  initial begin
    longint v;
    longint unsigned k2, lo, hi, mid;
    for (int i = 0; i < 32; i++) begin
      v = (i == 0) ? arctan_recip_q62(2) + arctan_recip_q62(3)
                   : arctan_recip_q62(64'd1 << i);
      atan_tab[i] = (v + (64'sd1 <<< 33)) >>> 34;
    end
    k2 = 64'd1 << 62;
    for (int i = 0; i < ITERS; i++) k2 = k2 - k2 / ((64'd1 << (2 * i)) + 64'd1);
    lo = 0;
    hi = 64'hFFFF_FFFF;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (mid * mid <= k2) lo = mid;
      else hi = mid - 1;
    end
    gain_q31 = lo;
  end

  // channel monitor
  always @(posedge clk) begin
    point_t exp_pt, got_pt;
    if (!rst_n) begin
      ang_start <= '0;
      ang_step  <= '0;
      rng_low   <= '0;
      rng_high  <= '1;
      win_en    <= 1'b0;
      win_from  <= '0;
      win_to    <= '0;
    end else begin
      // result word
      if (out_valid) begin
        got_pt.x = out_point_x;
        got_pt.y = out_point_y;
        if (pending_points.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected point x=%0d y=%0d", got_pt.x, got_pt.y);
          mismatch_count++;
        end else begin
          exp_pt = pending_points.pop_front();
          if (got_pt.x !== exp_pt.x || got_pt.y !== exp_pt.y) begin
            if (mismatch_count < 10)
              $display("point mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                       exp_pt.x, exp_pt.y, got_pt.x, got_pt.y);
            mismatch_count++;
          end
        end
      end
      // beam word
      if (start && !busy) begin
        if (project_beam(in_beam_range, in_range_finite, in_beam_index, exp_pt))
          pending_points = {pending_points, exp_pt};
      end
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_ANGLE_START:   ang_start <= cfg_data;
          CFG_ANGLE_STEP:    ang_step  <= cfg_data;
          CFG_RANGE_LOW:     rng_low   <= cfg_data;
          CFG_RANGE_HIGH:    rng_high  <= cfg_data;
          CFG_WINDOW_ENABLE: win_en    <= cfg_data[0];
          CFG_WINDOW_FROM:   win_from  <= cfg_data;
          CFG_WINDOW_TO:     win_to    <= cfg_data;
          default: ;
        endcase
      end
    end
    pending = pending_points.size();
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the scan point projection: clock, reset, beam and register stimulus, verdict.
module tb
  import lspp_pkg::*;
();

  localparam int CORDIC_ITERS    = 24;
  localparam int DRAIN_CYCLES    = 40;
  localparam int RANDOM_PHASES   = 8;
  localparam int BEAMS_PER_PHASE = 244;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  logic                 clk, rst_n;
  logic                 start, busy;
  logic [31:0]          in_beam_range;
  logic                 in_range_finite;
  logic [11:0]          in_beam_index;
  logic                 out_valid;
  logic signed [32:0]   out_point_x, out_point_y;
  logic                 cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  int                   mismatch_count, pending;
  bit                   gaps_on;
  logic [31:0]          cur_low, cur_high;

  laser_scan_point_projection_top #(.CORDIC_STAGES(CORDIC_ITERS)) dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_beam_range(in_beam_range), .in_range_finite(in_range_finite),
    .in_beam_index(in_beam_index),
    .out_valid(out_valid), .out_point_x(out_point_x), .out_point_y(out_point_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  scan_point_checker #(.CORDIC_STAGES(CORDIC_ITERS)) chk (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_beam_range(in_beam_range), .in_range_finite(in_range_finite),
    .in_beam_index(in_beam_index),
    .out_valid(out_valid), .out_point_x(out_point_x), .out_point_y(out_point_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .pending(pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // run limit
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // drop start, let every point out, then let dropped beams clear the pipe
  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register write word
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
  endtask

  // full register set, written with the pipe empty
  task automatic load_config(input logic [31:0] a_start, input logic [31:0] a_step,
                             input logic [31:0] lo, input logic [31:0] hi,
                             input logic en, input logic [31:0] w_from,
                             input logic [31:0] w_to, input bit poke_unmapped);
    wait_idle();
    cfg_write(CFG_ANGLE_START, a_start);
    cfg_write(CFG_ANGLE_STEP, a_step);
    cfg_write(CFG_RANGE_LOW, lo);
    cfg_write(CFG_RANGE_HIGH, hi);
    cfg_write(CFG_WINDOW_ENABLE, {$urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0, en});
    cfg_write(CFG_WINDOW_FROM, w_from);
    cfg_write(CFG_WINDOW_TO, w_to);
    if (poke_unmapped) cfg_write(CFG_UNMAPPED, $urandom);
    cfg_valid <= 1'b0;
    cur_low  = lo;
    cur_high = hi;
  endtask

  // one beam word, with an occasional idle burst ahead of it
  task automatic send_beam(input logic [31:0] r, input logic fin, input logic [11:0] idx);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_beam_range   <= r;
    in_range_finite <= fin;
    in_beam_index   <= idx;
    start           <= 1'b1;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    logic [31:0] a_start, a_step, lo, hi, w_from, w_to, r;
    logic [32:0] span;
    logic [11:0] idx;
    logic        en;
    int          n;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_beam_range   = '0;
    in_range_finite = 1'b0;
    in_beam_index   = '0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    gaps_on         = 1'b1;
    cur_low         = '0;
    cur_high        = '1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero angle, full range, saturating x at the top range
    send_beam(32'h0, 1'b1, 12'd0);
    send_beam(32'hFFFF_FFFF, 1'b1, 12'd4095);
    send_beam(32'hFFFF_FFFF, 1'b0, 12'd7);
    send_beam(32'd12345, 1'b1, 12'd2048);

    // extreme angle start and step, bound edges
    load_config(32'h8000_0000, 32'h7FFF_FFFF, 32'd100, 32'hFFFF_FFFE, 1'b0, 32'h0, 32'h0,
                1'b0);
    send_beam(32'd99, 1'b1, 12'd1);
    send_beam(32'd100, 1'b1, 12'd4095);
    send_beam(32'hFFFF_FFFE, 1'b1, 12'd2047);
    send_beam(32'hFFFF_FFFF, 1'b1, 12'd3);

    // inverted bounds drop everything; also poke the unmapped index
    load_config(32'h0, 32'h0, 32'd5000, 32'd4999, 1'b0, 32'h0, 32'h0, 1'b1);
    send_beam(32'd4999, 1'b1, 12'd5);
    send_beam(32'd5000, 1'b1, 12'd6);

    // plain window of -pi/2 .. pi/2 over a full-turn scan
    load_config(32'h0, 32'd411775, 32'h0, 32'hFFFF_FFFF, 1'b1,
                -32'sd421657428, 32'sd421657428, 1'b0);
    send_beam(32'h0100_0000, 1'b1, 12'd0);
    send_beam(32'h0100_0000, 1'b1, 12'd1023);
    send_beam(32'h0100_0000, 1'b1, 12'd1024);
    send_beam(32'h0100_0000, 1'b1, 12'd2048);
    send_beam(32'h0100_0000, 1'b1, 12'd3072);
    send_beam(32'h0100_0000, 1'b1, 12'd3100);

    // wrapping window from extreme register values
    load_config(32'h0, 32'd411775, 32'h0, 32'hFFFF_FFFF, 1'b1,
                32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_beam(32'h7654_3210, 1'b1, 12'd0);
    send_beam(32'h7654_3210, 1'b1, 12'd1500);
    send_beam(32'h7654_3210, 1'b1, 12'd2048);
    send_beam(32'h7654_3210, 1'b1, 12'd3500);
    send_beam(32'h7654_3210, 1'b1, 12'd4095);

    // random settings, mostly in-bounds scans with some noise
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      a_start = $urandom;
      if ($urandom_range(0, 2) == 0) begin
        a_step = $urandom;
      end else begin
        a_step = $urandom_range(800000, 0);
        if ($urandom_range(0, 1)) a_step = -a_step;
      end
      if (ph == 0) begin
        a_start = 32'h7FFF_FFFF;
        a_step  = 32'h8000_0000;
      end
      case ($urandom_range(0, 7))
        0: begin
          lo = $urandom;
          hi = $urandom;
        end
        1: begin
          lo = $urandom_range(32'hFFFF_FFFF, 32'h8000_0000);
          hi = $urandom_range(32'h7FFF_FFFF, 0);
        end
        default: begin
          lo = $urandom_range(1 << 20, 0);
          hi = 32'hFFFF_FFFF - $urandom_range(1 << 20, 0);
        end
      endcase
      en     = 1'($urandom_range(0, 1));
      w_from = $urandom;
      w_to   = $urandom;
      // last phase: widest bounds, no window, back-to-back beams
      if (ph == RANDOM_PHASES - 1) begin
        lo      = 32'h0;
        hi      = 32'hFFFF_FFFF;
        en      = 1'b0;
      end
      load_config(a_start, a_step, lo, hi, en, w_from, w_to, ph == 3);
      if (ph == RANDOM_PHASES - 1) gaps_on = 1'b0;
      idx = 12'($urandom);
      for (n = 0; n < BEAMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < 85) begin
          if (cur_low <= cur_high) begin
            span = {1'b0, cur_high} - {1'b0, cur_low} + 33'd1;
            r    = cur_low + 32'({1'b0, $urandom} % span);
          end else begin
            r = $urandom;
          end
          send_beam(r, 1'b1, idx);
          idx++;
        end else begin
          send_beam($urandom, 1'($urandom_range(0, 1)), 12'($urandom));
        end
      end
    end

    // let the last points out, bounded
    start <= 1'b0;
    for (n = 0; n < 5000 && pending != 0; n++) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
